>>> rtl/core/rgil_pkg.sv
// Shared types and constants for the random-grid interpolated lookup block.
package rgil_pkg;

    localparam int unsigned TABLE_DEPTH_DEF = 4096;
    localparam int unsigned FRAC_BITS       = 16;
    localparam logic [14:0] LEHMER_MULT     = 15'd16807;
    localparam logic [31:0] LEHMER_MOD      = 32'h7FFF_FFFF;
    localparam logic [12:0] GRID_RESET      = 13'd4096;
    localparam logic [30:0] SEED_RESET      = 31'd17;

    // Operand widths of the shared multiplier.
    localparam int unsigned MUL_AW  = 34;
    localparam int unsigned MUL_BW  = 18;
    localparam int unsigned PROD_W  = MUL_AW + MUL_BW;

    // Configuration register indexes (address bit 2).
    localparam logic REG_GRID = 1'b0;
    localparam logic REG_SEED = 1'b1;

    typedef enum logic [1:0] {
        FUNC_WRITE  = 2'd0,
        FUNC_LOOKUP = 2'd1,
        FUNC_CLEAR  = 2'd2,
        FUNC_NOP    = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        MUL_GEN,
        MUL_CELL,
        MUL_INTERP
    } t_mul_sel;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRITE,
        ST_CLEAR,
        ST_GEN_MUL,
        ST_GEN_RED,
        ST_CELL_MUL,
        ST_CELL_RED,
        ST_FRAC,
        ST_RD_LO,
        ST_RD_HI,
        ST_DIFF,
        ST_INTERP,
        ST_SAMPLE,
        ST_ACC,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_func              func;
        logic [11:0]        entry_index;
        logic signed [31:0] entry_value;
    } t_item;

    typedef struct packed {
        logic signed [31:0] sample_value;
        logic [11:0]        cell_index;
        logic signed [63:0] running_sum;
        logic               sum_saturated;
    } t_result;

    typedef struct packed {
        logic     ld_item;
        t_mul_sel mul_sel;
        logic     mul_en;
        logic     gen_upd;
        logic     cell_upd;
        logic     frac_upd;
        logic     rd_lo;
        logic     rd_hi;
        logic     lo_cap;
        logic     diff_upd;
        logic     sample_upd;
        logic     acc;
        logic     clr;
        logic     wr;
        logic     out_ld;
    } t_ctrl;

endpackage

>>> rtl/core/rgil_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rgil_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/rgil_seq.sv
// Sequencer that steps one item through the shared datapath.
module rgil_seq
    import rgil_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_func i_func,
    output logic  o_busy,
    output t_ctrl o_ctrl
);

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept = i_start && (r_state == ST_IDLE);
    assign o_busy = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    case (i_func)
                        FUNC_WRITE:  n_state = ST_WRITE;
                        FUNC_LOOKUP: n_state = ST_GEN_MUL;
                        FUNC_CLEAR:  n_state = ST_CLEAR;
                        default:     n_state = ST_DONE;
                    endcase
                end
            end
            ST_WRITE:    n_state = ST_DONE;
            ST_CLEAR:    n_state = ST_DONE;
            ST_GEN_MUL:  n_state = ST_GEN_RED;
            ST_GEN_RED:  n_state = ST_CELL_MUL;
            ST_CELL_MUL: n_state = ST_CELL_RED;
            ST_CELL_RED: n_state = ST_FRAC;
            ST_FRAC:     n_state = ST_RD_LO;
            ST_RD_LO:    n_state = ST_RD_HI;
            ST_RD_HI:    n_state = ST_DIFF;
            ST_DIFF:     n_state = ST_INTERP;
            ST_INTERP:   n_state = ST_SAMPLE;
            ST_SAMPLE:   n_state = ST_ACC;
            ST_ACC:      n_state = ST_DONE;
            ST_DONE:     n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl         = '0;
        o_ctrl.mul_sel = MUL_GEN;
        o_ctrl.ld_item = accept;
        case (r_state)
            ST_WRITE:    o_ctrl.wr = 1'b1;
            ST_CLEAR:    o_ctrl.clr = 1'b1;
            ST_GEN_MUL: begin
                o_ctrl.mul_sel = MUL_GEN;
                o_ctrl.mul_en  = 1'b1;
            end
            ST_GEN_RED:  o_ctrl.gen_upd = 1'b1;
            ST_CELL_MUL: begin
                o_ctrl.mul_sel = MUL_CELL;
                o_ctrl.mul_en  = 1'b1;
            end
            ST_CELL_RED: o_ctrl.cell_upd = 1'b1;
            ST_FRAC:     o_ctrl.frac_upd = 1'b1;
            ST_RD_LO:    o_ctrl.rd_lo = 1'b1;
            ST_RD_HI: begin
                o_ctrl.rd_hi  = 1'b1;
                o_ctrl.lo_cap = 1'b1;
            end
            ST_DIFF:     o_ctrl.diff_upd = 1'b1;
            ST_INTERP: begin
                o_ctrl.mul_sel = MUL_INTERP;
                o_ctrl.mul_en  = 1'b1;
            end
            ST_SAMPLE:   o_ctrl.sample_upd = 1'b1;
            ST_ACC:      o_ctrl.acc = 1'b1;
            ST_DONE:     o_ctrl.out_ld = 1'b1;
            default: begin
            end
        endcase
    end

endmodule

>>> rtl/core/rgil_dp.sv
// Datapath: generator, shared multiplier, modular reduction, interpolation and sum.
module rgil_dp
    import rgil_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_ctrl       i_ctrl,
    input  t_item       i_item,
    input  logic [12:0] i_grid,
    input  logic [30:0] i_seed,
    output t_result     o_result,
    output logic        o_done
);

    localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH);
    localparam int unsigned G_MAX  = (TABLE_DEPTH > 8191) ? 8191 : TABLE_DEPTH;
    localparam logic [12:0] G_MAX_W = 13'(G_MAX);

    t_item                    r_item;
    logic [30:0]              r_gen;
    logic signed [PROD_W-1:0] r_prod;
    logic [12:0]              r_cell;
    logic [30:0]              r_rem;
    logic [15:0]              r_frac;
    logic signed [31:0]       r_lo;
    logic signed [32:0]       r_diff;
    logic signed [31:0]       r_sample;
    logic signed [63:0]       r_sum;
    logic                     r_clip;
    t_result                  r_res;
    logic                     r_done;

    logic [12:0]              grid_g;
    logic [12:0]              gm1;
    logic [12:0]              gm2;
    logic signed [MUL_AW-1:0] mul_a;
    logic signed [MUL_BW-1:0] mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic [31:0]              gen_sum;
    logic [31:0]              cell_sum;
    logic                     cell_wrap;
    logic [31:0]              frac_sum;
    logic [PROD_W-1:0]        prod_shr;
    logic [64:0]              sum_ext;
    logic                     wr_ok;
    logic [ADDR_W-1:0]        raddr;
    logic [31:0]              rdata;

    // Grid size in use, clamped between two and the table depth (at most 8191).
    always_comb begin
        if (i_grid < 13'd2) begin
            grid_g = 13'd2;
        end else if (i_grid > G_MAX_W) begin
            grid_g = G_MAX_W;
        end else begin
            grid_g = i_grid;
        end
    end
    assign gm1 = grid_g - 13'd1;
    assign gm2 = grid_g - 13'd2;

    always_comb begin
        case (i_ctrl.mul_sel)
            MUL_GEN: begin
                mul_a = {3'b000, r_gen};
                mul_b = {3'b000, LEHMER_MULT};
            end
            MUL_CELL: begin
                mul_a = {3'b000, r_gen};
                mul_b = {5'b00000, gm1};
            end
            MUL_INTERP: begin
                mul_a = {r_diff[32], r_diff};
                mul_b = {2'b00, r_frac};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // Since 2^31 is one more than the modulus, high part plus low part is
    // congruent to the product and stays below twice the modulus.
    assign gen_sum   = {17'd0, r_prod[45:31]} + {1'b0, r_prod[30:0]};
    assign cell_sum  = {19'd0, r_prod[43:31]} + {1'b0, r_prod[30:0]};
    assign cell_wrap = (cell_sum >= LEHMER_MOD);
    assign frac_sum  = {16'd0, r_rem[30:15]} + {1'b0, r_rem[14:0], 16'd0};
    assign prod_shr  = r_prod >>> FRAC_BITS;
    assign sum_ext   = {r_sum[63], r_sum} + {{33{r_sample[31]}}, r_sample};
    assign wr_ok     = (32'(r_item.entry_index) < 32'(TABLE_DEPTH));

    assign raddr = i_ctrl.rd_hi ? ADDR_W'(r_cell + 13'd1) : ADDR_W'(r_cell);

    rgil_ram #(
        .WIDTH (32),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (i_ctrl.wr && wr_ok),
        .i_waddr (ADDR_W'(r_item.entry_index)),
        .i_wdata (r_item.entry_value),
        .i_re    (i_ctrl.rd_lo || i_ctrl.rd_hi),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_ctrl.ld_item) begin
            r_item <= i_item;
        end
        if (i_ctrl.mul_en) begin
            r_prod <= mul_p;
        end
        if (i_ctrl.cell_upd) begin
            r_cell <= cell_wrap ? (r_prod[43:31] + 13'd1) : r_prod[43:31];
            r_rem  <= cell_wrap ? 31'(cell_sum - LEHMER_MOD) : cell_sum[30:0];
        end
        if (i_ctrl.frac_upd) begin
            r_frac <= (frac_sum >= LEHMER_MOD) ? (r_rem[30:15] + 16'd1) : r_rem[30:15];
            r_cell <= (r_cell > gm2) ? gm2 : r_cell;
        end
        if (i_ctrl.lo_cap) begin
            r_lo <= rdata;
        end
        if (i_ctrl.diff_upd) begin
            r_diff <= {rdata[31], rdata} - {r_lo[31], r_lo};
        end
        if (i_ctrl.sample_upd) begin
            r_sample <= r_lo + prod_shr[31:0];
        end
        if (i_ctrl.out_ld) begin
            if (r_item.func == FUNC_LOOKUP) begin
                r_res.sample_value <= r_sample;
                r_res.cell_index   <= r_cell[11:0];
            end else begin
                r_res.sample_value <= '0;
                r_res.cell_index   <= '0;
            end
            r_res.running_sum   <= r_sum;
            r_res.sum_saturated <= r_clip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen  <= SEED_RESET;
            r_sum  <= '0;
            r_clip <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= i_ctrl.out_ld;
            if (i_ctrl.clr) begin
                r_gen  <= i_seed;
                r_sum  <= '0;
                r_clip <= 1'b0;
            end else if (i_ctrl.gen_upd) begin
                r_gen <= (gen_sum >= LEHMER_MOD) ? 31'(gen_sum - LEHMER_MOD) : gen_sum[30:0];
            end
            if (i_ctrl.acc) begin
                if (sum_ext[64] != sum_ext[63]) begin
                    // Overflow: clip toward the sign of the true sum.
                    r_sum  <= sum_ext[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
                    r_clip <= 1'b1;
                end else begin
                    r_sum <= sum_ext[63:0];
                end
            end
        end
    end

    assign o_result = r_res;
    assign o_done   = r_done;

    a_clear_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.clr |=> (r_sum == 64'sd0) && !r_clip)
        else $error("sum or clip flag not cleared by a clear word");

    a_cell_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.rd_lo |-> (r_cell <= gm2))
        else $error("cell index beyond the grid at table read");

    a_other_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && (r_item.func != FUNC_LOOKUP))
            |-> (r_res.sample_value == 32'sd0) && (r_res.cell_index == 12'd0))
        else $error("non-lookup word reports a sample or index");

endmodule

>>> rtl/core/random_grid_interpolated_lookup.sv
// Random-grid interpolated lookup: top level with configuration registers.
//
// A command word is taken at a rising edge where start is high and busy is
// low. func selects a table write, one random lookup, a clear of the sum
// (which also reloads the generator from seed_start), or no operation.
// Every word gives exactly one result word on o_result, shown for one
// cycle with o_done high; the receiver cannot hold it off.
// A lookup steps through the sequencer states in order, using in turn
// the single shared multiplier (three products per lookup), the two
// modular reductions and the two reads of the one table read port; a
// write or a clear passes through its own state before the done state,
// and an unused code goes straight to it. grid_points and seed_start
// are to be written over the APB port only while the block is idle; the
// block does not enforce this. pready is always high. Reset loads
// grid_points with 4096, seed_start and the generator with 17, and zeroes
// the sum and clip flag. Table contents are undefined until written.
module random_grid_interpolated_lookup
    import rgil_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_item       i_item,
    output t_result     o_result,
    output logic        o_done,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [12:0] r_grid;
    logic [30:0] r_seed;
    logic        cfg_wr;
    t_ctrl       ctrl;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid <= GRID_RESET;
            r_seed <= SEED_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_GRID) begin
                r_grid <= pwdata[12:0];
            end else begin
                r_seed <= pwdata[30:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_SEED) ? {1'b0, r_seed} : {19'd0, r_grid};

    rgil_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_func  (i_item.func),
        .o_busy  (busy),
        .o_ctrl  (ctrl)
    );

    rgil_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (ctrl),
        .i_item   (i_item),
        .i_grid   (r_grid),
        .i_seed   (r_seed),
        .o_result (o_result),
        .o_done   (o_done)
    );

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not make the block busy");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for two cycles");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while the sequencer is still working");

endmodule

>>> bench/tb.sv
// Self-checking testbench for the random-grid interpolated lookup block.
module tb;
    import rgil_pkg::*;

    localparam int unsigned DEPTH        = TABLE_DEPTH_DEF;
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned PHASE_WORDS  = 85;
    localparam logic signed [63:0] SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] SUM_MIN = 64'sh8000_0000_0000_0000;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start   = 1'b0;
    logic        busy;
    t_item       i_item  = '0;
    t_result     o_result;
    logic        o_done;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    random_grid_interpolated_lookup dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Register values as last written; both the stimulus planner and the
    // predictor read them, which is safe because writes happen only when idle.
    logic [12:0] cfg_grid = GRID_RESET;
    logic [30:0] cfg_seed = SEED_RESET;

    // Predictor state, advanced at each accepted word.
    logic [30:0]        lut_gen  = SEED_RESET;
    logic signed [31:0] lut_vals [DEPTH];
    longint             lut_sum  = 0;
    bit                 lut_clip = 1'b0;

    // Planner state: generator position and which entries hold data, so that
    // a lookup is never sent before both of its entries are written.
    logic [30:0] plan_gen = SEED_RESET;
    bit          plan_loaded [DEPTH];

    t_item   pending_cmds [$];
    t_result due_results  [$];
    int      send_idle_pct = 0;
    bit      taken = 1'b0;
    int      mismatches = 0;

    function automatic logic [30:0] lehmer_next(input logic [30:0] s);
        return 31'((64'(s) * 64'(LEHMER_MULT)) % 64'(LEHMER_MOD));
    endfunction

    function automatic int unsigned used_grid(input logic [12:0] g);
        if (g < 13'd2) return 2;
        if (g > DEPTH) return DEPTH;
        return 32'(g);
    endfunction

    // Splits a draw into the lower cell and a Q0.16 position inside it.
    function automatic void split_draw(input logic [30:0] s, input int unsigned g,
                                       output int unsigned cell_j,
                                       output int unsigned frac);
        logic [63:0] prod;
        logic [63:0] rem;
        prod   = 64'(s) * 64'(g - 1);
        cell_j = 32'(prod / 64'(LEHMER_MOD));
        rem    = prod % 64'(LEHMER_MOD);
        frac   = 32'((rem << FRAC_BITS) / 64'(LEHMER_MOD));
        if (cell_j > g - 2) cell_j = g - 2;
    endfunction

    task automatic interp_result(input t_item cmd, output t_result res);
        int unsigned        cell_j;
        int unsigned        frac;
        longint             lo;
        longint             hi;
        longint             sample;
        logic signed [64:0] wide;
        res = '0;
        case (cmd.func)
            FUNC_WRITE: lut_vals[cmd.entry_index] = cmd.entry_value;
            FUNC_LOOKUP: begin
                lut_gen = lehmer_next(lut_gen);
                split_draw(lut_gen, used_grid(cfg_grid), cell_j, frac);
                lo     = lut_vals[cell_j];
                hi     = lut_vals[cell_j + 1];
                sample = lo + (((hi - lo) * longint'(frac)) >>> FRAC_BITS);
                wide   = lut_sum;
                wide   = wide + sample;
                if (wide[64] != wide[63]) begin
                    lut_sum  = wide[64] ? SUM_MIN : SUM_MAX;
                    lut_clip = 1'b1;
                end else begin
                    lut_sum = longint'(wide[63:0]);
                end
                res.sample_value = 32'(sample);
                res.cell_index   = 12'(cell_j);
            end
            FUNC_CLEAR: begin
                lut_sum  = 0;
                lut_clip = 1'b0;
                lut_gen  = cfg_seed;
            end
            default: ;
        endcase
        res.running_sum   = lut_sum;
        res.sum_saturated = lut_clip;
    endtask

    task automatic check_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Checks result words first, since a word strobed now belongs to an
    // earlier command than one accepted at the same edge.
    always @(posedge i_clk) begin
        t_result want;
        if (o_done === 1'b1) begin
            if (due_results.size() == 0) begin
                $error("result word arrived with none expected");
                mismatches++;
            end else begin
                want = due_results.pop_front();
                check_field("sample_value", want.sample_value, o_result.sample_value);
                check_field("cell_index", want.cell_index, o_result.cell_index);
                check_field("running_sum", want.running_sum, o_result.running_sum);
                check_field("sum_saturated", want.sum_saturated, o_result.sum_saturated);
            end
        end
        if (i_rst_n && start && !busy) begin
            interp_result(i_item, want);
            due_results.push_back(want);
            taken = 1'b1;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || taken) begin
            taken = 1'b0;
            if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_item <= pending_cmds.pop_front();
                start  <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            default: return $urandom();
        endcase
    endfunction

    task automatic queue_cmd(input t_func f, input logic [11:0] idx,
                             input logic [31:0] val);
        t_item cmd;
        cmd.func        = f;
        cmd.entry_index = idx;
        cmd.entry_value = val;
        case (f)
            FUNC_WRITE:  plan_loaded[idx] = 1'b1;
            FUNC_LOOKUP: plan_gen = lehmer_next(plan_gen);
            FUNC_CLEAR:  plan_gen = cfg_seed;
            default: ;
        endcase
        pending_cmds.push_back(cmd);
    endtask

    task automatic queue_lookup();
        int unsigned cell_j;
        int unsigned frac;
        split_draw(lehmer_next(plan_gen), used_grid(cfg_grid), cell_j, frac);
        for (int k = cell_j; k <= cell_j + 1; k++) begin
            if (!plan_loaded[k]) queue_cmd(FUNC_WRITE, 12'(k), rand_sample());
        end
        queue_cmd(FUNC_LOOKUP, 12'($urandom), $urandom);
    endtask

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || start || due_results.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Writes one register, then reads it back. Called at a falling edge.
    task automatic reg_access(input logic idx, input logic [31:0] data);
        logic [31:0] want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_GRID) cfg_grid = data[12:0];
        else cfg_seed = data[30:0];
        want = (idx == REG_GRID) ? 32'(cfg_grid) : 32'(cfg_seed);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want) begin
            $error("prdata at %0d: expected %0d, got %0d", {idx, 2'b00}, want, prdata);
            mismatches++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_config(input logic [31:0] grid_word, input logic [31:0] seed_word);
        wait_drained();
        reg_access(REG_GRID, grid_word);
        reg_access(REG_SEED, seed_word);
    endtask

    initial begin
        logic [31:0] grid_word;
        int unsigned g;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Table extremes, an unused code, then lookups from the reset seed, before and after a clear.
        queue_cmd(FUNC_WRITE, 12'd0, 32'h8000_0000);
        queue_cmd(FUNC_WRITE, 12'd1, 32'h7FFF_FFFF);
        queue_cmd(FUNC_WRITE, 12'(DEPTH - 1), 32'h7FFF_FFFF);
        queue_cmd(FUNC_WRITE, 12'(DEPTH - 2), 32'h8000_0000);
        queue_cmd(FUNC_NOP, '1, '1);
        queue_lookup();
        queue_lookup();
        queue_cmd(FUNC_CLEAR, '0, '0);
        queue_lookup();

        // A seed just below the modulus puts the first draw in the top cell.
        set_config(32'hFFFF_E000 | DEPTH, 32'hFFFF_FFFE);
        queue_cmd(FUNC_CLEAR, '1, '1);
        repeat (2) queue_lookup();

        // Smallest grid: every lookup spans the full-scale step between two entries.
        set_config(32'd2, 32'd1);
        queue_cmd(FUNC_CLEAR, '0, '0);
        repeat (3) queue_lookup();

        // Grid below range clamps to two; a zero seed pins the generator at zero.
        set_config(32'd0, 32'h8000_0000);
        queue_cmd(FUNC_CLEAR, '0, '0);
        repeat (2) queue_lookup();

        // Grid above range clamps to the table depth; a seed equal to the
        // modulus also collapses to zero.
        set_config(32'd8191, 32'hFFFF_FFFF);
        queue_cmd(FUNC_CLEAR, '0, '0);
        repeat (2) queue_lookup();

        for (int ph = 0; ph < 9; ph++) begin
            case (ph)
                0, 4, 8: grid_word = DEPTH;
                1, 7:    grid_word = 2;
                2, 5:    grid_word = $urandom_range(3, 16);
                3:       grid_word = $urandom_range(0, 8191);
                default: grid_word = $urandom_range(17, DEPTH);
            endcase
            grid_word[31:13] = 19'($urandom);
            set_config(grid_word, {1'($urandom), 31'($urandom_range(1, 32'h7FFF_FFFE))});
            case (ph % 3)
                0: send_idle_pct = 0;
                1: send_idle_pct = 88;
                default: send_idle_pct = 25;
            endcase
            g = used_grid(cfg_grid);
            queue_cmd(FUNC_CLEAR, 12'($urandom), $urandom);
            repeat (PHASE_WORDS) begin
                case ($urandom_range(99)) inside
                    [0:54]:  queue_lookup();
                    [55:79]: queue_cmd(FUNC_WRITE,
                                       $urandom_range(1) ? 12'($urandom_range(g - 1))
                                                         : 12'($urandom),
                                       rand_sample());
                    [80:87]: queue_cmd(FUNC_CLEAR, 12'($urandom), $urandom);
                    default: queue_cmd(FUNC_NOP, 12'($urandom), $urandom);
                endcase
            end
        end

        wait_drained();
        if (mismatches == 0 && due_results.size() == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #12_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> files.f
rtl/core/rgil_pkg.sv
rtl/core/rgil_ram.sv
rtl/core/rgil_seq.sv
rtl/core/rgil_dp.sv
rtl/core/random_grid_interpolated_lookup.sv
bench/tb.sv
